### sv/ifmt_pkg.sv
package ifmt_pkg;

    // defaults for the top level parameters
    localparam int DIGIT_SLOTS_DEF   = 24;
    localparam int MAX_WIDTH_DEF     = 63;
    localparam int MAX_PRECISION_DEF = 40;

    // fixed field widths
    localparam int VALUE_W    = 64;
    localparam int FUNC_W     = 3;
    localparam int WIDTH_W    = 6;
    localparam int PREC_W     = 7;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = 7;   // layout arithmetic, holds up to 127
    localparam int MAX_DIGITS = 22;  // octal digits of a 64-bit value

    // input tdata layout
    localparam int LEFT_BIT   = 64;
    localparam int ZERO_BIT   = 65;
    localparam int PLUS_BIT   = 66;
    localparam int SPACE_BIT  = 67;
    localparam int ALT_BIT    = 68;
    localparam int WIDTH_LSB  = 69;
    localparam int PREC_LSB   = 75;
    localparam int S_TDATA_W  = 88;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X_UPPER = 8'h58;
    localparam logic [CHAR_W-1:0] CH_X_LOWER = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER_OFS = 8'h37;  // 'A' minus ten
    localparam logic [CHAR_W-1:0] CH_LOWER_OFS = 8'h57;  // 'a' minus ten

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SDEC = 3'd0,
        FUNC_UDEC = 3'd1,
        FUNC_HEXL = 3'd2,
        FUNC_HEXU = 3'd3,
        FUNC_OCT  = 3'd4,
        FUNC_PTR  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_OCT
    } radix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LAYOUT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        radix_t radix;
        logic   clear;
        logic   shift;
    } cell_ctl_t;

    typedef struct packed {
        logic   load;
        radix_t radix;
    } conv_ctl_t;

    typedef struct packed {
        logic               sign_en;
        logic [CHAR_W-1:0]  sign_char;
        logic               alt_hex;
        logic               alt_oct;
        logic               upper;
        logic               left;
        logic               zero;
        logic               prec_none;
        logic [5:0]         prec;
        logic [WIDTH_W-1:0] width;
    } fmt_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10))
            return CH_ZERO + dx;
        else if (upper)
            return CH_UPPER_OFS + dx;
        else
            return CH_LOWER_OFS + dx;
    endfunction

endpackage

### sv/ifmt_cell.sv
module ifmt_cell (
    input  logic                         clk,
    input  ifmt_pkg::cell_ctl_t          ctl,
    input  logic                         carry_in,
    output logic                         carry_out,
    output logic [ifmt_pkg::DIGIT_W-1:0] digit,
    output logic [ifmt_pkg::DIGIT_W-1:0] digit_next
);
    import ifmt_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] adj;
    logic [DIGIT_W-1:0] shifted;

    // one shift-and-correct step per cycle while shift is set
    always_comb
    begin
        adj       = digit_reg;
        carry_out = 1'b0;
        shifted   = digit_reg;
        unique case (ctl.radix)
            RADIX_DEC:
            begin
                // bcd correction before the doubling
                adj       = (digit_reg >= DIGIT_W'(5)) ? digit_reg + DIGIT_W'(3) : digit_reg;
                carry_out = adj[3];
                shifted   = {adj[2:0], carry_in};
            end
            RADIX_HEX:
            begin
                carry_out = digit_reg[3];
                shifted   = {digit_reg[2:0], carry_in};
            end
            RADIX_OCT:
            begin
                carry_out = digit_reg[2];
                shifted   = {1'b0, digit_reg[1:0], carry_in};
            end
            default:
            begin
                carry_out = 1'b0;
                shifted   = digit_reg;
            end
        endcase

        if (ctl.clear)
            digit_next = '0;
        else if (ctl.shift)
            digit_next = shifted;
        else
            digit_next = digit_reg;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

### sv/ifmt_chain.sv
module ifmt_chain #(
    parameter int  DIGIT_SLOTS = ifmt_pkg::DIGIT_SLOTS_DEF,
    localparam int IDX_W       = $clog2(DIGIT_SLOTS),
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ifmt_pkg::conv_ctl_t          ctl,
    input  logic [ifmt_pkg::VALUE_W-1:0] magnitude,
    input  logic [IDX_W-1:0]             rd_index,
    output logic [ifmt_pkg::DIGIT_W-1:0] rd_digit,
    output logic [CNT_W-1:0]             digit_count,
    output logic                         busy
);
    import ifmt_pkg::*;

    localparam int BITS_W = $clog2(VALUE_W + 1);

    logic [VALUE_W-1:0] quot_reg, quot_next;
    logic [BITS_W-1:0]  bits_reg, bits_next;
    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    radix_t             radix_reg, radix_next;

    cell_ctl_t          cctl;
    logic [DIGIT_SLOTS:0] carry;
    logic [DIGIT_W-1:0] digits [DIGIT_SLOTS];
    logic [DIGIT_W-1:0] dnext  [DIGIT_SLOTS];

    assign cctl.radix = radix_reg;
    assign cctl.clear = ctl.load;
    assign cctl.shift = busy_reg;
    assign carry[0]   = quot_reg[VALUE_W-1];

    // row of digit cells, bits enter at the bottom and carry upward
    for (genvar i = 0; i < DIGIT_SLOTS; i++)
    begin : g_cell
        ifmt_cell u_cell (
            .clk        (clk),
            .ctl        (cctl),
            .carry_in   (carry[i]),
            .carry_out  (carry[i+1]),
            .digit      (digits[i]),
            .digit_next (dnext[i])
        );
    end

    always_comb
    begin
        quot_next  = quot_reg;
        bits_next  = bits_reg;
        busy_next  = busy_reg;
        count_next = count_reg;
        radix_next = radix_reg;
        if (ctl.load)
        begin
            quot_next  = magnitude;
            bits_next  = BITS_W'(VALUE_W);
            busy_next  = 1'b1;
            count_next = '0;
            radix_next = ctl.radix;
        end
        else if (busy_reg)
        begin
            quot_next = quot_reg << 1;
            bits_next = bits_reg - BITS_W'(1);
            if (bits_reg == BITS_W'(1))
                busy_next = 1'b0;
            // the prefix only grows, so the digit count rises by at most one a step
            if (count_reg < CNT_W'(DIGIT_SLOTS))
            begin
                if (dnext[count_reg[IDX_W-1:0]] != '0)
                    count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg  <= '0;
            bits_reg  <= '0;
            busy_reg  <= 1'b0;
            count_reg <= '0;
            radix_reg <= RADIX_DEC;
        end
        else
        begin
            quot_reg  <= quot_next;
            bits_reg  <= bits_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
            radix_reg <= radix_next;
        end
    end

    assign rd_digit    = (32'(rd_index) < DIGIT_SLOTS) ? digits[rd_index] : '0;
    assign digit_count = count_reg;
    assign busy        = busy_reg;

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> busy_reg && count_reg == '0)
        else $error("conversion did not start after load");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond the longest 64-bit value");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !carry[DIGIT_SLOTS])
        else $error("carry left the top cell");

endmodule

### sv/ifmt_emit.sv
module ifmt_emit #(
    parameter int  DIGIT_SLOTS = ifmt_pkg::DIGIT_SLOTS_DEF,
    parameter int  MAX_WIDTH   = ifmt_pkg::MAX_WIDTH_DEF,
    localparam int IDX_W       = $clog2(DIGIT_SLOTS),
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ifmt_pkg::fmt_t               fmt,
    input  logic                         layout,
    input  logic [CNT_W-1:0]             digit_count,
    output logic [IDX_W-1:0]             rd_index,
    input  logic [ifmt_pkg::DIGIT_W-1:0] rd_digit,
    output logic                         busy,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ifmt_pkg::CHAR_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tlast
);
    import ifmt_pkg::*;

    logic [POS_W-1:0] n, prec, wid;
    logic [POS_W-1:0] zeros_a, zeros_b, zeros_c, zeros_d;
    logic [POS_W-1:0] plen, len, fill, fill_d, lead, tail, tot;
    logic [POS_W-1:0] b1, b2, b3, b4, total;
    logic             hex_pfx, pad_zero;

    logic [POS_W-1:0]  b1_reg, b2_reg, b3_reg, b4_reg, total_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              active_reg, active_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] pfx0, pfx1;
    logic              is_last, advance;

    // field layout from the digit count and the flags
    always_comb
    begin
        n    = POS_W'(digit_count);
        prec = POS_W'(fmt.prec);
        wid  = POS_W'(fmt.width);

        zeros_a = (!fmt.prec_none && prec > n) ? prec - n : '0;
        // zero value still prints one digit unless precision is exactly zero
        zeros_b = (n == '0 && (fmt.prec_none || prec != '0) && zeros_a == '0)
                  ? POS_W'(1) : zeros_a;
        hex_pfx = !fmt.sign_en && fmt.alt_hex && n != '0;
        plen    = fmt.sign_en ? POS_W'(1) : (hex_pfx ? POS_W'(2) : '0);
        // octal alternate form needs a leading zero
        zeros_c = (!fmt.sign_en && !hex_pfx && fmt.alt_oct && zeros_b == '0)
                  ? POS_W'(1) : zeros_b;

        len      = plen + zeros_c + n;
        fill     = (wid > len) ? wid - len : '0;
        pad_zero = fmt.zero && !fmt.left && fmt.prec_none;
        zeros_d  = pad_zero ? zeros_c + fill : zeros_c;
        fill_d   = pad_zero ? '0 : fill;
        lead     = fmt.left ? '0 : fill_d;
        tail     = fmt.left ? fill_d : '0;

        b1    = lead;
        b2    = b1 + plen;
        b3    = b2 + zeros_d;
        b4    = b3 + n;
        tot   = b4 + tail;
        total = (tot > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : tot;
    end

    // character at the current position
    always_comb
    begin
        pfx0     = fmt.sign_en ? fmt.sign_char : CH_ZERO;
        pfx1     = fmt.upper ? CH_X_UPPER : CH_X_LOWER;
        rd_index = IDX_W'(b4_reg - pos_reg - POS_W'(1));
        if (pos_reg < b1_reg)
            ch = CH_SPACE;
        else if (pos_reg < b2_reg)
            ch = (pos_reg == b1_reg) ? pfx0 : pfx1;
        else if (pos_reg < b3_reg)
            ch = CH_ZERO;
        else if (pos_reg < b4_reg)
            ch = digit_char(rd_digit, fmt.upper);
        else
            ch = CH_SPACE;
        is_last = (pos_reg == total_reg - POS_W'(1));
    end

    assign advance = active_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (layout)
        begin
            active_next = (total != '0);
            pos_next    = '0;
        end
        else if (advance)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (is_last)
                active_next = 1'b0;
        end

        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (layout)
        begin
            b1_reg    <= b1;
            b2_reg    <= b2;
            b3_reg    <= b3;
            b4_reg    <= b4;
            total_reg <= total;
        end
        if (advance)
        begin
            out_data_reg <= ch;
            out_last_reg <= is_last;
        end
    end

    assign busy          = active_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_pos_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> pos_reg < total_reg)
        else $error("emit position ran past the field");

    a_layout_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        layout |=> pos_reg == '0)
        else $error("position not rewound by layout");

endmodule

### sv/integer_field_formatter_top.sv
// printf-style integer field formatter. Each input transfer carries one field request
// (64-bit value, conversion kind on tuser, flags, width, precision); the block
// produces the formatted field as a stream of ASCII characters, one per output
// transfer, with tlast on the final character. An empty field (zero printed with
// precision zero and no width, sign or octal alternate zero) and an unknown
// conversion kind produce no output at all. The value is converted by a row of
// digit cells that takes one value bit per cycle; each item then passes through
// the conversion, a state that sees the conversion finish, a layout step, the
// emission of its characters, held back whenever the output side stalls, and
// the return to idle. A field holds at most 63 characters, and an item with an
// unknown conversion kind is taken and dropped straight from idle.
// Items are taken one at a time; the last character of an item may still sit in
// the output register while the next item is being converted. No clearing pass
// runs after reset.
module integer_field_formatter_top #(
    parameter int DIGIT_SLOTS   = ifmt_pkg::DIGIT_SLOTS_DEF,
    parameter int MAX_WIDTH     = ifmt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PRECISION = ifmt_pkg::MAX_PRECISION_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // value[63:0], left_flag, zero_flag, plus_flag, space_flag, alt_flag,
    // width[5:0], precision[6:0], zero pad to 88 bits
    input  logic [ifmt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func[2:0]
    input  logic [ifmt_pkg::FUNC_W-1:0]    s_axis_tuser,
    // output character stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_char[7:0]
    output logic [ifmt_pkg::CHAR_W-1:0]    m_axis_tdata,
    // last character of the field
    output logic                           m_axis_tlast
);
    import ifmt_pkg::*;

    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

    state_t state_reg, state_next;
    fmt_t   fmt_reg;
    fmt_t   fmt_in;
    radix_t radix_in;
    logic   func_ok;

    logic [VALUE_W-1:0] value_in, magnitude;
    logic               neg;
    logic [PREC_W-1:0]  prec_raw;
    logic [WIDTH_W-1:0] width_raw;
    logic               plus_in, space_in;

    conv_ctl_t          conv_ctl;
    logic               conv_busy;
    logic               emit_busy;
    logic               layout;
    logic [IDX_W-1:0]   rd_index;
    logic [DIGIT_W-1:0] rd_digit;
    logic [CNT_W-1:0]   digit_count;

    // request decode: resolve conversion kind into radix, sign and prefix rules
    always_comb
    begin
        value_in  = s_axis_tdata[VALUE_W-1:0];
        prec_raw  = s_axis_tdata[PREC_LSB +: PREC_W];
        width_raw = s_axis_tdata[WIDTH_LSB +: WIDTH_W];
        plus_in   = s_axis_tdata[PLUS_BIT];
        space_in  = s_axis_tdata[SPACE_BIT];
        neg       = 1'b0;
        magnitude = value_in;
        func_ok   = 1'b1;
        radix_in  = RADIX_DEC;

        fmt_in.sign_en   = 1'b0;
        fmt_in.sign_char = CH_SPACE;
        fmt_in.alt_hex   = 1'b0;
        fmt_in.alt_oct   = 1'b0;
        fmt_in.upper     = 1'b0;
        fmt_in.left      = s_axis_tdata[LEFT_BIT];
        fmt_in.zero      = s_axis_tdata[ZERO_BIT];
        // negative precision means none given
        fmt_in.prec_none = prec_raw[PREC_W-1];
        fmt_in.prec      = (prec_raw[5:0] > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                               : prec_raw[5:0];
        fmt_in.width     = (width_raw > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                             : width_raw;

        unique case (func_t'(s_axis_tuser))
            FUNC_SDEC:
            begin
                neg       = value_in[VALUE_W-1];
                magnitude = neg ? VALUE_W'(0) - value_in : value_in;
                fmt_in.sign_en = neg || plus_in || space_in;
                if (neg)
                    fmt_in.sign_char = CH_MINUS;
                else if (plus_in)
                    fmt_in.sign_char = CH_PLUS;
                else
                    fmt_in.sign_char = CH_SPACE;
            end
            FUNC_UDEC:
            begin
                radix_in = RADIX_DEC;
            end
            FUNC_HEXL:
            begin
                radix_in       = RADIX_HEX;
                fmt_in.alt_hex = s_axis_tdata[ALT_BIT];
            end
            FUNC_HEXU:
            begin
                radix_in       = RADIX_HEX;
                fmt_in.alt_hex = s_axis_tdata[ALT_BIT];
                fmt_in.upper   = 1'b1;
            end
            FUNC_OCT:
            begin
                radix_in       = RADIX_OCT;
                fmt_in.alt_oct = s_axis_tdata[ALT_BIT];
            end
            FUNC_PTR:
            begin
                // pointer: lower hex, 0x unless the value is zero, no precision, right-justified
                radix_in         = RADIX_HEX;
                fmt_in.alt_hex   = 1'b1;
                fmt_in.left      = 1'b0;
                fmt_in.zero      = 1'b0;
                fmt_in.prec_none = 1'b1;
            end
            default:
            begin
                func_ok = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // unknown kinds are taken and dropped
                if (s_axis_tvalid && func_ok)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (!conv_busy)
                    state_next = ST_LAYOUT;
            end
            ST_LAYOUT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // last character may still wait in the output register
                if (!emit_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready  = 1'b0;
        conv_ctl.load  = 1'b0;
        conv_ctl.radix = radix_in;
        layout         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                conv_ctl.load = s_axis_tvalid && func_ok;
            end
            ST_CONV:
            begin
                s_axis_tready = 1'b0;
            end
            ST_LAYOUT:
            begin
                layout = 1'b1;
            end
            ST_EMIT:
            begin
                s_axis_tready = 1'b0;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // request held for the layout and emit phases
    always_ff @(posedge clk)
    begin
        if (conv_ctl.load)
            fmt_reg <= fmt_in;
    end

    ifmt_chain #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (conv_ctl),
        .magnitude   (magnitude),
        .rd_index    (rd_index),
        .rd_digit    (rd_digit),
        .digit_count (digit_count),
        .busy        (conv_busy)
    );

    ifmt_emit #(
        .DIGIT_SLOTS (DIGIT_SLOTS),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .fmt           (fmt_reg),
        .layout        (layout),
        .digit_count   (digit_count),
        .rd_index      (rd_index),
        .rd_digit      (rd_digit),
        .busy          (emit_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/sv/integer_field_formatter_top_test.sv
module integer_field_formatter_top_test;

    import ifmt_pkg::*;

    // conversion codes the block must drop without output
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_B = 3'd7;

    // raw precision code for "none given"
    localparam logic [PREC_W-1:0] PREC_NONE = 7'h7F;

    localparam int FIELD_CAP    = 63;   // characters per field at most
    localparam int PREC_CAP     = 40;   // precision saturation
    localparam int RANDOM_ITEMS = 128;  // random requests with a defined conversion
    localparam int PAUSE_AT     = 40;   // request that waits for an empty expectation store
    localparam int CALM_FIRST   = 70;   // no idling on either side in this request range
    localparam int CALM_LAST    = 110;
    localparam int DRAIN_CYCLES = 200;  // longer than one conversion plus a full field

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic               left;
        logic               zero;
        logic               plus;
        logic               space;
        logic               alt;
        logic [WIDTH_W-1:0] width;
        logic [PREC_W-1:0]  prec;
    } field_req_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } field_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [FUNC_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;

    field_req_t  field_reqs [$];      // requests not yet offered to the block
    field_req_t  offered_req;         // request currently on the input bus
    field_char_t expected_chars [$];  // characters predicted but not yet seen
    logic        req_taken = 1'b0;    // input transfer happened at the last rising edge
    int          reqs_offered = 0;
    int          chars_seen = 0;
    int          mismatch_count = 0;
    bit          calm;

    integer_field_formatter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // works out the characters of one printf integer field and queues them
    function automatic void format_field(input field_req_t r);
        int                prec;
        int                fld_width;
        int                radix;
        int                n;
        int                zeros;
        int                fill;
        int                plen;
        int                len;
        int                digit [24];
        logic [VALUE_W-1:0] mag;
        bit                neg;
        bit                upper;
        bit                lft;
        bit                zpad;
        bit                pls;
        bit                spc;
        bit                alt;
        logic [CHAR_W-1:0] prefix [2];
        logic [CHAR_W-1:0] chars [$];
        field_char_t       rec;

        // negative raw precision means none given, large ones saturate
        if (r.prec[PREC_W-1])
            prec = -1;
        else if (int'(r.prec) > PREC_CAP)
            prec = PREC_CAP;
        else
            prec = int'(r.prec);
        fld_width = int'(r.width);
        mag   = r.value;
        neg   = 1'b0;
        upper = 1'b0;
        lft   = r.left;
        zpad  = r.zero;
        pls   = r.plus;
        spc   = r.space;
        alt   = r.alt;

        case (r.func)
            FUNC_SDEC:
            begin
                radix = 10;
                if (mag[VALUE_W-1])
                begin
                    neg = 1'b1;
                    mag = 64'd0 - mag;
                end
            end
            FUNC_UDEC:
            begin
                radix = 10;
                pls = 1'b0;
                spc = 1'b0;
            end
            FUNC_HEXL:
            begin
                radix = 16;
                pls = 1'b0;
                spc = 1'b0;
            end
            FUNC_HEXU:
            begin
                radix = 16;
                upper = 1'b1;
                pls = 1'b0;
                spc = 1'b0;
            end
            FUNC_OCT:
            begin
                radix = 8;
                pls = 1'b0;
                spc = 1'b0;
            end
            FUNC_PTR:
            begin
                // pointer: lower hex with 0x unless zero, user flags and precision dropped
                radix = 16;
                lft  = 1'b0;
                zpad = 1'b0;
                pls  = 1'b0;
                spc  = 1'b0;
                alt  = 1'b1;
                prec = -1;
            end
            default:
                return;
        endcase

        // digits, least significant first
        n = 0;
        while (mag != 0)
        begin
            digit[n] = int'(mag % radix);
            mag = mag / radix;
            n++;
        end

        zeros = (prec > n) ? prec - n : 0;
        if (n == 0 && prec != 0 && zeros == 0)
            zeros = 1;

        plen = 0;
        if (neg)
        begin
            prefix[0] = "-";
            plen = 1;
        end
        else if (pls)
        begin
            prefix[0] = "+";
            plen = 1;
        end
        else if (spc)
        begin
            prefix[0] = " ";
            plen = 1;
        end
        else if (alt && radix == 16 && n != 0)
        begin
            prefix[0] = "0";
            prefix[1] = upper ? "X" : "x";
            plen = 2;
        end
        else if (alt && radix == 8 && zeros == 0)
            zeros = 1;

        len  = plen + zeros + n;
        fill = (fld_width > len) ? fld_width - len : 0;
        if (zpad && !lft && prec < 0)
        begin
            zeros += fill;
            fill = 0;
        end

        if (!lft)
            repeat (fill) chars.push_back(" ");
        for (int i = 0; i < plen; i++)
            chars.push_back(prefix[i]);
        repeat (zeros) chars.push_back("0");
        for (int i = n - 1; i >= 0; i--)
        begin
            if (digit[i] < 10)
                chars.push_back(CHAR_W'("0" + digit[i]));
            else if (upper)
                chars.push_back(CHAR_W'("A" + digit[i] - 10));
            else
                chars.push_back(CHAR_W'("a" + digit[i] - 10));
        end
        if (lft)
            repeat (fill) chars.push_back(" ");
        while (chars.size() > FIELD_CAP)
            void'(chars.pop_back());

        foreach (chars[i])
        begin
            rec.ch   = chars[i];
            rec.last = (i == chars.size() - 1);
            expected_chars.push_back(rec);
        end
    endfunction

    task automatic add_req(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                           input logic left, input logic zero, input logic plus,
                           input logic space, input logic alt,
                           input logic [WIDTH_W-1:0] width, input logic [PREC_W-1:0] prec);
        field_req_t r;
        r.func  = func;
        r.value = value;
        r.left  = left;
        r.zero  = zero;
        r.plus  = plus;
        r.space = space;
        r.alt   = alt;
        r.width = width;
        r.prec  = prec;
        field_reqs.push_back(r);
    endtask

    // both sides run without gaps in the middle of the run
    assign calm = (reqs_offered >= CALM_FIRST) && (reqs_offered < CALM_LAST);

    // input driver: offers the next request at the falling edge once the
    // previous one was taken, with random gaps and one hold-off until drained
    always @(negedge clk)
    begin
        field_req_t nxt;
        bit         hold;
        if (rst_n)
        begin
            if (!s_axis_tvalid || req_taken)
            begin
                hold = (reqs_offered == PAUSE_AT) && (expected_chars.size() != 0);
                if (field_reqs.size() != 0 && !hold && (calm || $urandom_range(0, 99) >= 22))
                begin
                    nxt = field_reqs.pop_front();
                    offered_req   <= nxt;
                    // tdata: value, left, zero, plus, space, alt, width, precision, pad
                    s_axis_tdata  <= {6'd0, nxt.prec, nxt.width, nxt.alt, nxt.space,
                                      nxt.plus, nxt.zero, nxt.left, nxt.value};
                    s_axis_tuser  <= nxt.func;
                    s_axis_tvalid <= 1'b1;
                    reqs_offered  <= reqs_offered + 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            // output backpressure
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    // monitor: checks each character transfer, then predicts for a taken request
    always @(posedge clk)
    begin
        field_char_t exp_char;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("char %0d: unexpected transfer %h last %b",
                                 chars_seen, m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end
                else
                begin
                    exp_char = expected_chars.pop_front();
                    if (m_axis_tdata !== exp_char.ch || m_axis_tlast !== exp_char.last)
                    begin
                        if (mismatch_count < 10)
                            $display("char %0d: expected %h last %b, got %h last %b",
                                     chars_seen, exp_char.ch, exp_char.last,
                                     m_axis_tdata, m_axis_tlast);
                        mismatch_count++;
                    end
                end
                chars_seen++;
            end
            // a taken request can produce nothing before the next edge
            if (s_axis_tvalid && s_axis_tready)
                format_field(offered_req);
            req_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    // stimulus and end of run
    initial
    begin
        int                good_reqs;
        logic [FUNC_W-1:0] func;
        logic [VALUE_W-1:0] value;
        logic [WIDTH_W-1:0] width;
        logic [PREC_W-1:0]  prec;

        // directed requests: extremes, each conversion, each corner of the spec
        add_req(FUNC_SDEC, 64'd0, 0, 0, 0, 0, 0, 0, PREC_NONE);
        add_req(FUNC_SDEC, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 0, PREC_NONE);
        add_req(FUNC_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 1, 0, 0, 0, PREC_NONE);
        add_req(FUNC_SDEC, -1, 0, 1, 0, 0, 0, 10, PREC_NONE);
        add_req(FUNC_SDEC, 64'd42, 1, 0, 1, 0, 0, 8, PREC_NONE);
        add_req(FUNC_SDEC, 64'd42, 0, 0, 0, 1, 0, 6, 7'd5);
        // unsigned conversions drop plus and space
        add_req(FUNC_UDEC, '1, 0, 0, 1, 1, 1, 0, PREC_NONE);
        add_req(FUNC_HEXL, 64'hDEAD_BEEF, 0, 1, 0, 0, 1, 20, PREC_NONE);
        add_req(FUNC_HEXU, '1, 0, 0, 0, 0, 1, 0, 7'd40);
        // alternate hex of zero has no 0x
        add_req(FUNC_HEXL, 64'd0, 0, 0, 0, 0, 1, 4, PREC_NONE);
        add_req(FUNC_OCT, 64'd8, 0, 0, 0, 0, 1, 0, PREC_NONE);
        add_req(FUNC_OCT, 64'd0, 0, 0, 0, 0, 1, 0, 7'd0);
        add_req(FUNC_OCT, '1, 1, 0, 0, 0, 1, 30, PREC_NONE);
        // pointer ignores user flags and precision, keeps width
        add_req(FUNC_PTR, 64'd0, 1, 1, 1, 1, 0, 0, 7'd5);
        add_req(FUNC_PTR, 64'h0000_7FFF_1234_ABCD, 0, 1, 0, 0, 0, 24, 7'd0);
        // zero with precision zero: empty field, pure fill, sign only
        add_req(FUNC_SDEC, 64'd0, 0, 0, 0, 0, 0, 0, 7'd0);
        add_req(FUNC_UDEC, 64'd0, 1, 0, 0, 0, 0, 5, 7'd0);
        add_req(FUNC_SDEC, 64'd0, 0, 0, 1, 0, 0, 0, 7'd0);
        // undefined conversions give nothing
        add_req(FUNC_UNDEF_A, 64'd123, 0, 0, 0, 0, 0, 10, PREC_NONE);
        add_req(FUNC_UNDEF_B, '1, 1, 1, 1, 1, 1, 63, 7'd3);
        // most negative raw precision, precision above the cap
        add_req(FUNC_UDEC, 64'd7, 0, 0, 0, 0, 0, 0, 7'h40);
        add_req(FUNC_UDEC, 64'd7, 0, 0, 0, 0, 0, 0, 7'h3F);
        // zero flag loses to left flag and to a given precision
        add_req(FUNC_SDEC, -12345, 1, 1, 0, 0, 0, 63, PREC_NONE);
        add_req(FUNC_HEXU, 64'hABC, 0, 1, 0, 0, 1, 12, 7'd6);
        add_req(FUNC_SDEC, 64'hFFFF, 0, 0, 0, 0, 0, 63, 7'd63);

        // random requests, mostly short fields
        good_reqs = 0;
        while (good_reqs < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                func = FUNC_W'($urandom_range(FUNC_UNDEF_A, FUNC_UNDEF_B));
            else
            begin
                func = FUNC_W'($urandom_range(FUNC_SDEC, FUNC_PTR));
                good_reqs++;
            end
            case ($urandom_range(0, 5))
                0: value = 64'd0;
                1: value = 64'($urandom_range(0, 1000));
                2: value = {$urandom, $urandom};
                3: value = 64'd0 - 64'($urandom_range(1, 1000));
                4: value = 64'd1 << $urandom_range(0, 63);
                default: value = (64'd1 << $urandom_range(0, 63)) - 64'd1;
            endcase
            width = ($urandom_range(0, 99) < 85) ? WIDTH_W'($urandom_range(0, 12))
                                                 : WIDTH_W'($urandom_range(13, 63));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: prec = PREC_NONE;
                8, 9:                   prec = PREC_W'($urandom_range(64, 127));
                10, 11, 12, 13, 14, 15, 16: prec = PREC_W'($urandom_range(0, 8));
                default:                prec = PREC_W'($urandom_range(9, 63));
            endcase
            add_req(func, value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), width, prec);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all requests taken, then all characters seen, then a quiet tail
        while (field_reqs.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_chars.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("integer_field_formatter_top test passed");
        else
            $display("integer_field_formatter_top test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("integer_field_formatter_top test failed");
        $finish;
    end

endmodule

### integer_field_formatter_top.f
sv/ifmt_pkg.sv
sv/ifmt_cell.sv
sv/ifmt_chain.sv
sv/ifmt_emit.sv
sv/integer_field_formatter_top.sv
tb/sv/integer_field_formatter_top_test.sv
